FILE: design/dielectric_scatter_direction_assert.svh
// Assertion macros for the dielectric scatter direction block.
`ifndef DIELECTRIC_SCATTER_DIRECTION_ASSERT_SVH
`define DIELECTRIC_SCATTER_DIRECTION_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define DSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define DSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dsd_pkg.sv
// Package for the dielectric scatter direction block: constants, types and helpers.
package dsd_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int HALF_FX   = 1 << (FRAC_BITS - 1);
    localparam int ETA_MAX   = 256 * ONE_FX;
    // Below this index the exit ratio 1/n saturates at ETA_MAX
    localparam int ETA_IDX_MIN = (ONE_FX * ONE_FX) / ETA_MAX;
    localparam int IDX_W     = 14;
    localparam logic [IDX_W-1:0] IDX_RESET = 14'd6144;

    // Pipeline stage map
    localparam int ST_IN    = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_LSQ0  = 3;   // 16 steps of the length root
    localparam int LSQ_N    = 16;
    localparam int ST_EDIV0 = 3;   // 21 steps of the exit ratio divide
    localparam int EDIV_N   = 21;
    localparam int ST_RDIV0 = 3;   // 12 steps of the Fresnel ratio divide
    localparam int RDIV_N   = 12;
    localparam int ST_ULEN  = 19;
    localparam int ST_UDIV0 = 20;  // 13 steps of the normalize divides
    localparam int UDIV_N   = 13;
    localparam int ST_UFIN  = 33;
    localparam int ST_UN    = 34;
    localparam int ST_DT    = 35;
    localparam int ST_DTSQ  = 36;
    localparam int ST_SIN   = 37;
    localparam int ST_ESIN  = 38;
    localparam int ST_DISC  = 39;
    localparam int ST_SQI   = 40;
    localparam int ST_DSQ0  = 41;  // 24 steps of the discriminant root
    localparam int DSQ_N    = 24;
    localparam int ST_SQ    = 65;
    localparam int ST_XX    = 66;
    localparam int ST_X2    = 67;
    localparam int ST_X2SQ  = 68;
    localparam int ST_X4    = 69;
    localparam int ST_X4X   = 70;
    localparam int ST_X5    = 71;
    localparam int ST_PX    = 72;
    localparam int ST_PROB  = 73;
    localparam int ST_OUT   = 74;
    localparam int NSTAGE   = 75;

    // Everything an item carries down the pipeline
    typedef struct packed {
        logic [2:0][15:0] d;
        logic [2:0][15:0] nv;
        logic [15:0]      rnd_frac;
        logic [IDX_W-1:0] idx;
        logic             exiting;
        logic [2:0][31:0] pdn;
        logic [2:0][30:0] pdd;
        logic [33:0]      dotdn;
        logic [47:0]      sv;
        logic [47:0]      sr;
        logic [15:0]      len;
        logic [2:0][28:0] urem;
        logic [2:0]       usg;
        logic [2:0][12:0] uq;
        logic [24:0]      erem;
        logic [20:0]      eq;
        logic [26:0]      rrem;
        logic             rsg;
        logic [11:0]      rq;
        logic [2:0][13:0] u;
        logic [20:0]      eta;
        logic [12:0]      r;
        logic [2:0][29:0] pun;
        logic [41:0]      etaeta;
        logic [25:0]      rr;
        logic [17:0]      dt;
        logic [28:0]      eta2;
        logic [12:0]      r0;
        logic [31:0]      dtdt;
        logic [21:0]      k;
        logic [2:0][33:0] ndt;
        logic [20:0]      sin2;
        logic [2:0][21:0] rndt;
        logic [2:0][37:0] kn;
        logic [50:0]      esin;
        logic [2:0][22:0] w;
        logic [2:0][27:0] refd;
        logic [37:0]      disc;
        logic             tir;
        logic [2:0][44:0] pw;
        logic [2:0][33:0] t;
        logic [12:0]      x;
        logic [2:0][41:0] ns;
        logic [2:0][29:0] s;
        logic [2:0][34:0] res;
        logic [25:0]      xprod;
        logic [12:0]      x2;
        logic [12:0]      x4;
        logic [12:0]      x5;
        logic [13:0]      prob;
        logic [2:0][15:0] o;
        logic             refl;
    } pipe_t;

    // One result transaction
    typedef struct packed {
        logic             tir;
        logic             refl;
        logic [2:0][15:0] dir;
    } out_t;

    // Drop FRAC_BITS fraction bits, round half away from zero
    function automatic logic signed [63:0] rnd_fx(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + 64'(HALF_FX)) >> FRAC_BITS;
        return v[63] ? -signed'(m) : signed'(m);
    endfunction

    // Clamp to the signed 16-bit range
    function automatic logic [15:0] sat16(input logic signed [63:0] v);
        logic [15:0] q;
        if (v > 64'sd32767)
            q = 16'h7fff;
        else if (v < -64'sd32768)
            q = 16'h8000;
        else
            q = v[15:0];
        return q;
    endfunction

endpackage

FILE: design/dielectric_scatter_direction.sv
// Top level of the dielectric scatter direction block: full pipeline and output buffer.
// Scatters one ray at a dielectric surface: normalizes the incoming direction,
// picks entering or exiting from the sign of its dot product with the normal,
// tries Snell refraction and falls back to reflection on total internal
// reflection or when random_fraction is below the Schlick Fresnel probability.
// One ray is accepted every clock cycle unless the skid entry of the output buffer
// is full. Each ray passes through 75 pipeline stages and then the output register.
// The depth is set by the two square roots (16 and 24 stages, one result bit
// per stage) and the normalize divides (13 stages, one quotient bit each).
// The refractive index register is sampled when a ray enters, so write it only
// while no ray is in flight. A two-entry output buffer lets the pipeline keep
// accepting while one result waits for the downstream side.
`include "dielectric_scatter_direction_assert.svh"

module dielectric_scatter_direction
    import dsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [13:0]   cfg_wr_data,   // refractive_index
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, random_fraction
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [47:0]   m_axis_tdata,  // out_dir_x, out_dir_y, out_dir_z
    output logic [1:0]    m_axis_tuser   // took_reflection, total_internal
);

    logic [IDX_W-1:0]  refr_reg;
    pipe_t             in_item;
    pipe_t             pipe_reg [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    out_t              out_reg;
    out_t              skid_reg;
    out_t              last_res;
    logic              out_vld_reg;
    logic              skid_vld_reg;
    logic              core_adv;
    logic              take_out;
    logic              pipe_emit;

    // Work done by one pipeline stage
    function automatic pipe_t stage_fn(input int k, input pipe_t a);
        pipe_t              b;
        logic signed [63:0] acc;
        logic [47:0]        bitv;
        logic [47:0]        trial;
        logic [34:0]        eden;
        logic [27:0]        rden;
        logic [14:0]        rdiv;
        logic [29:0]        uden;
        logic [15:0]        dabs;
        logic [13:0]        mag;
        int                 j;
        b = a;
        // Lane products
        if (k == ST_MUL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b.pdn[i] = 32'(signed'(a.d[i]) * signed'(a.nv[i]));
                b.pdd[i] = 31'(signed'(a.d[i]) * signed'(a.d[i]));
            end
        end
        // Dot product, squared length and divider setup
        if (k == ST_SUM)
        begin
            acc = 64'(signed'(a.pdn[0])) + 64'(signed'(a.pdn[1]))
                + 64'(signed'(a.pdn[2]));
            b.dotdn   = 34'(acc);
            b.exiting = acc > 0;
            b.sv      = 48'(a.pdd[0]) + 48'(a.pdd[1]) + 48'(a.pdd[2]);
            b.sr      = '0;
            b.erem    = 25'(1 << (2 * FRAC_BITS)) + 25'(a.idx >> 1);
            b.eq      = '0;
            b.rsg     = a.idx < 14'(ONE_FX);
            mag       = b.rsg ? 14'(14'(ONE_FX) - a.idx) : 14'(a.idx - 14'(ONE_FX));
            rdiv      = 15'(a.idx) + 15'(ONE_FX);
            b.rrem    = (27'(mag) << FRAC_BITS) + 27'(rdiv >> 1);
            b.rq      = '0;
        end
        // Length root, one bit pair per stage
        if (k >= ST_LSQ0 && k < ST_LSQ0 + LSQ_N)
        begin
            j     = k - ST_LSQ0;
            bitv  = 48'(1) << (2 * (LSQ_N - 1 - j));
            trial = a.sr + bitv;
            if (a.sv >= trial)
            begin
                b.sv = a.sv - trial;
                b.sr = (a.sr >> 1) + bitv;
            end
            else
            begin
                b.sr = a.sr >> 1;
            end
        end
        // Exit ratio 1/n, one quotient bit per stage
        if (k >= ST_EDIV0 && k < ST_EDIV0 + EDIV_N)
        begin
            j    = EDIV_N - 1 - (k - ST_EDIV0);
            eden = 35'(a.idx) << j;
            if (35'(a.erem) >= eden)
            begin
                b.erem  = 25'(35'(a.erem) - eden);
                b.eq[j] = 1'b1;
            end
        end
        // Fresnel ratio (n-1)/(n+1), one quotient bit per stage
        if (k >= ST_RDIV0 && k < ST_RDIV0 + RDIV_N)
        begin
            j    = RDIV_N - 1 - (k - ST_RDIV0);
            rdiv = 15'(a.idx) + 15'(ONE_FX);
            rden = 28'(rdiv) << j;
            if (28'(a.rrem) >= rden)
            begin
                b.rrem  = 27'(28'(a.rrem) - rden);
                b.rq[j] = 1'b1;
            end
        end
        // Capture length and set up the normalize divides
        if (k == ST_ULEN)
        begin
            b.len = a.sr[15:0];
            for (int i = 0; i < 3; i++)
            begin
                dabs       = a.d[i][15] ? 16'(-a.d[i]) : a.d[i];
                b.usg[i]   = a.d[i][15];
                b.urem[i]  = (29'(dabs) << FRAC_BITS) + 29'(a.sr[15:1]);
                b.uq[i]    = '0;
            end
        end
        // Normalize divides, one quotient bit per stage
        if (k >= ST_UDIV0 && k < ST_UDIV0 + UDIV_N)
        begin
            j    = UDIV_N - 1 - (k - ST_UDIV0);
            uden = 30'(a.len) << j;
            for (int i = 0; i < 3; i++)
            begin
                if (30'(a.urem[i]) >= uden)
                begin
                    b.urem[i]  = 29'(30'(a.urem[i]) - uden);
                    b.uq[i][j] = 1'b1;
                end
            end
        end
        // Apply signs, pick the index ratio
        if (k == ST_UFIN)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (a.len == '0)
                    b.u[i] = '0;
                else
                    b.u[i] = a.usg[i] ? -14'(a.uq[i]) : 14'(a.uq[i]);
            end
            if (a.exiting)
                b.eta = 21'(a.idx);
            else if (a.idx < 14'(ETA_IDX_MIN))
                b.eta = 21'(ETA_MAX);
            else
                b.eta = a.eq;
            b.r = a.rsg ? -13'(a.rq) : 13'(a.rq);
        end
        if (k == ST_UN)
        begin
            for (int i = 0; i < 3; i++)
                b.pun[i] = 30'(signed'(a.u[i]) * signed'(a.nv[i]));
            b.etaeta = 42'(a.eta) * 42'(a.eta);
            b.rr     = 26'(signed'(a.r) * signed'(a.r));
        end
        if (k == ST_DT)
        begin
            acc    = 64'(signed'(a.pun[0])) + 64'(signed'(a.pun[1]))
                   + 64'(signed'(a.pun[2]));
            b.dt   = 18'(rnd_fx(acc));
            b.eta2 = 29'(rnd_fx(64'(a.etaeta)));
            b.r0   = 13'(rnd_fx(64'(a.rr)));
        end
        if (k == ST_DTSQ)
        begin
            b.dtdt = 32'(signed'(a.dt) * signed'(a.dt));
            b.k    = 22'(rnd_fx(64'(signed'(a.dotdn))));
            for (int i = 0; i < 3; i++)
                b.ndt[i] = 34'(signed'(a.nv[i]) * signed'(a.dt));
        end
        if (k == ST_SIN)
        begin
            acc    = 64'(ONE_FX) - rnd_fx(64'(a.dtdt));
            b.sin2 = 21'(acc);
            for (int i = 0; i < 3; i++)
            begin
                b.rndt[i] = 22'(rnd_fx(64'(signed'(a.ndt[i]))));
                b.kn[i]   = 38'(signed'(a.k) * signed'(a.nv[i]));
            end
        end
        if (k == ST_ESIN)
        begin
            b.esin = 51'(signed'({1'b0, a.eta2}) * signed'(a.sin2));
            for (int i = 0; i < 3; i++)
            begin
                b.w[i]    = 23'(signed'(a.u[i]) - signed'(a.rndt[i]));
                acc       = 64'(signed'(a.d[i])) - rnd_fx(64'(signed'({a.kn[i], 1'b0})));
                b.refd[i] = 28'(acc);
            end
        end
        // Discriminant and total internal reflection
        if (k == ST_DISC)
        begin
            acc    = 64'(ONE_FX) - rnd_fx(64'(signed'(a.esin)));
            b.disc = 38'(acc);
            b.tir  = acc <= 0;
            for (int i = 0; i < 3; i++)
                b.pw[i] = 45'(signed'({1'b0, a.eta}) * signed'(a.w[i]));
        end
        if (k == ST_SQI)
        begin
            b.sv = a.tir ? '0 : (48'(a.disc[35:0]) << FRAC_BITS);
            b.sr = '0;
            for (int i = 0; i < 3; i++)
                b.t[i] = 34'(rnd_fx(64'(signed'(a.pw[i]))));
        end
        // Discriminant root, one bit pair per stage
        if (k >= ST_DSQ0 && k < ST_DSQ0 + DSQ_N)
        begin
            j     = k - ST_DSQ0;
            bitv  = 48'(1) << (2 * (DSQ_N - 1 - j));
            trial = a.sr + bitv;
            if (a.sv >= trial)
            begin
                b.sv = a.sv - trial;
                b.sr = (a.sr >> 1) + bitv;
            end
            else
            begin
                b.sr = a.sr >> 1;
            end
        end
        // Schlick cosine and normal term of the refraction
        if (k == ST_SQ)
        begin
            acc = a.exiting ? 64'(a.sr[24:0]) : -64'(signed'(a.dt));
            acc = 64'(ONE_FX) - acc;
            if (acc < 0)
                b.x = '0;
            else if (acc > 64'(ONE_FX))
                b.x = 13'(ONE_FX);
            else
                b.x = 13'(acc);
            for (int i = 0; i < 3; i++)
                b.ns[i] = 42'(signed'(a.nv[i]) * signed'({1'b0, a.sr[24:0]}));
        end
        if (k == ST_XX)
        begin
            b.xprod = 26'(a.x) * 26'(a.x);
            for (int i = 0; i < 3; i++)
                b.s[i] = 30'(rnd_fx(64'(signed'(a.ns[i]))));
        end
        if (k == ST_X2)
        begin
            b.x2 = 13'(rnd_fx(64'(a.xprod)));
            for (int i = 0; i < 3; i++)
            begin
                if (a.exiting)
                    acc = 64'(signed'(a.t[i])) + 64'(signed'(a.s[i]));
                else
                    acc = 64'(signed'(a.t[i])) - 64'(signed'(a.s[i]));
                b.res[i] = 35'(acc);
            end
        end
        if (k == ST_X2SQ)
            b.xprod = 26'(a.x2) * 26'(a.x2);
        if (k == ST_X4)
            b.x4 = 13'(rnd_fx(64'(a.xprod)));
        if (k == ST_X4X)
            b.xprod = 26'(a.x4) * 26'(a.x);
        if (k == ST_X5)
            b.x5 = 13'(rnd_fx(64'(a.xprod)));
        if (k == ST_PX)
            b.xprod = 26'(13'(ONE_FX) - a.r0) * 26'(a.x5);
        if (k == ST_PROB)
            b.prob = 14'(a.r0) + 14'(rnd_fx(64'(a.xprod)));
        // Choose the direction and saturate
        if (k == ST_OUT)
        begin
            b.refl = a.tir || ({2'b00, a.rnd_frac} < {a.prob, 4'b0000});
            for (int i = 0; i < 3; i++)
            begin
                if (b.refl)
                    b.o[i] = sat16(64'(signed'(a.refd[i])));
                else
                    b.o[i] = sat16(64'(signed'(a.res[i])));
            end
        end
        return b;
    endfunction

    // Hold the refractive index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            refr_reg <= IDX_RESET;
        else if (cfg_wr_en)
            refr_reg <= cfg_wr_data;
    end

    // Unpack the input transaction; index zero means 1.0
    always_comb
    begin
        in_item          = '0;
        in_item.d[0]     = s_axis_tdata[15:0];
        in_item.d[1]     = s_axis_tdata[31:16];
        in_item.d[2]     = s_axis_tdata[47:32];
        in_item.nv[0]    = s_axis_tdata[63:48];
        in_item.nv[1]    = s_axis_tdata[79:64];
        in_item.nv[2]    = s_axis_tdata[95:80];
        in_item.rnd_frac = s_axis_tdata[111:96];
        in_item.idx      = (refr_reg == '0) ? IDX_W'(ONE_FX) : refr_reg;
    end

    // Advance the whole pipeline unless the output buffer is full
    assign core_adv      = !skid_vld_reg;
    assign s_axis_tready = core_adv;
    assign pipe_emit     = vld_reg[NSTAGE-1] && core_adv;
    assign take_out      = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        last_res.dir  = pipe_reg[NSTAGE-1].o;
        last_res.refl = pipe_reg[NSTAGE-1].refl;
        last_res.tir  = pipe_reg[NSTAGE-1].tir;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (core_adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (core_adv)
            pipe_reg[ST_IN] <= in_item;
    end

    for (genvar g = 1; g < NSTAGE; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (core_adv)
                pipe_reg[g] <= stage_fn(g, pipe_reg[g-1]);
        end
    end

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (take_out)
        begin
            out_vld_reg  <= skid_vld_reg || pipe_emit;
            skid_vld_reg <= 1'b0;
        end
        else if (pipe_emit)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
            out_reg <= skid_vld_reg ? skid_reg : last_res;
        else if (pipe_emit)
            skid_reg <= last_res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg.dir;
    assign m_axis_tuser  = {out_reg.tir, out_reg.refl};

    `DSD_ASSERT_SAME(a_skid_has_out, skid_vld_reg, out_vld_reg, "skid entry without output entry")
    `DSD_ASSERT_SAME(a_tir_reflects, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "total internal reflection without reflection")
    `DSD_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted transaction did not enter the pipeline")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the dielectric scatter direction block.
`timescale 1ns / 1ps

module testbench;
    import dsd_pkg::*;

    localparam int LATENCY = 76;
    localparam int N_RANDOM = 1530;

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic [13:0]   cfg_wr_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [111:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [47:0]   m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    // Expected scatter: dir fields, then reflection flag, then total internal flag
    typedef struct packed {
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic        refl;
        logic        tir;
    } scatter_t;

    // Directed row: ray, optional hand-typed answer
    typedef struct {
        logic [111:0] ray;
        bit           typed;
        scatter_t     answer;
    } ray_row_t;

    scatter_t    scatter_q[$];
    logic [13:0] index_reg;
    int          mismatch_count;
    int          checked_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          refl_count;
    int          tir_count;

    dielectric_scatter_direction u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Round half away from zero after dropping the fraction bits
    function automatic longint fx_round(input longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return v < 0 ? -m : m;
    endfunction

    // Rounded quotient, positive divisor
    function automatic longint fx_div(input longint num, input longint den);
        longint m;
        longint q;
        m = num < 0 ? -num : num;
        q = (m + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    // Truncated integer square root
    function automatic longint int_sqrt(input longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // Work out the scattered direction for one ray under the current index
    function automatic scatter_t scatter_ray(input logic [111:0] ray, input logic [13:0] n_idx);
        longint d[3];
        longint nv[3];
        longint u[3];
        longint res[3];
        longint one;
        longint dotdn;
        longint len2;
        longint len;
        longint dt;
        longint idx;
        longint eta;
        longint eta2;
        longint sin2;
        longint disc;
        longint sq;
        longint cosine;
        longint r;
        longint r0;
        longint x;
        longint x2;
        longint x4;
        longint x5;
        longint prob;
        longint k;
        longint t;
        longint s;
        bit exiting;
        bit tir;
        bit refl;
        scatter_t o;
        one = longint'(1) << FRAC_BITS;
        dotdn = 0;
        len2 = 0;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(ray[16*i +: 16]));
            nv[i] = longint'($signed(ray[48 + 16*i +: 16]));
            dotdn += d[i] * nv[i];
            len2 += d[i] * d[i];
        end
        len = int_sqrt(len2);
        exiting = dotdn > 0;
        for (int i = 0; i < 3; i++)
            u[i] = len > 0 ? fx_div(d[i] * one, len) : 0;
        dt = fx_round(u[0] * nv[0] + u[1] * nv[1] + u[2] * nv[2]);
        idx = n_idx == 0 ? one : longint'(n_idx);
        eta = exiting ? idx : fx_div(one * one, idx);
        if (eta > 256 * one)
            eta = 256 * one;
        eta2 = fx_round(eta * eta);
        sin2 = one - fx_round(dt * dt);
        disc = one - fx_round(eta2 * sin2);
        tir = disc <= 0;
        if (!tir)
            sq = int_sqrt(disc * one);
        cosine = exiting ? sq : -dt;
        r = fx_div((idx - one) * one, idx + one);
        r0 = fx_round(r * r);
        x = one - cosine;
        if (x < 0)
            x = 0;
        if (x > one)
            x = one;
        x2 = fx_round(x * x);
        x4 = fx_round(x2 * x2);
        x5 = fx_round(x4 * x);
        prob = r0 + fx_round((one - r0) * x5);
        refl = tir || (longint'(ray[111:96]) * one < prob * 65536);
        if (refl)
        begin
            k = fx_round(dotdn);
            for (int i = 0; i < 3; i++)
                res[i] = d[i] - fx_round(2 * k * nv[i]);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = fx_round(eta * (u[i] - fx_round(nv[i] * dt)));
                s = fx_round(nv[i] * sq);
                res[i] = exiting ? t + s : t - s;
            end
        end
        o.dx = clamp16(res[0]);
        o.dy = clamp16(res[1]);
        o.dz = clamp16(res[2]);
        o.refl = refl;
        o.tir = tir;
        return o;
    endfunction

    function automatic logic [111:0] pack_ray(input int dx, input int dy, input int dz,
                                              input int nx, input int ny, input int nz,
                                              input int rf);
        return {rf[15:0], nz[15:0], ny[15:0], nx[15:0], dz[15:0], dy[15:0], dx[15:0]};
    endfunction

    // Unit normal along a random axis with random sign, or fully random noise
    function automatic logic [111:0] random_ray();
        int ax;
        int sg;
        logic [47:0] nrm;
        ax = $urandom_range(0, 2);
        sg = $urandom_range(0, 1) ? 4096 : -4096;
        nrm = '0;
        nrm[16*ax +: 16] = sg[15:0];
        case ($urandom_range(0, 9))
            0: return 112'({$urandom, $urandom, $urandom, $urandom});
            1: return {16'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom})};
            2, 3: return {16'($urandom), nrm, 16'($urandom_range(0, 8191) - 4096),
                          16'($urandom_range(0, 8191) - 4096),
                          16'($urandom_range(0, 8191) - 4096)};
            default: return {16'($urandom), nrm, 16'($urandom_range(0, 4095) - 2048),
                             16'($urandom_range(0, 4095) - 2048),
                             16'($urandom_range(0, 4095) - 2048)};
        endcase
    endfunction

    // Offer one ray and hold it until accepted; drop valid only while idling
    task automatic send_ray(input logic [111:0] ray);
        while (($urandom % 100) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ray;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scatter_q.push_back(scatter_ray(ray, index_reg));
    endtask

    // Drain every outstanding result, then let the pipeline settle
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (scatter_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_index(input logic [13:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        index_reg = value;
    endtask

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (($urandom % 100) >= recv_idle_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        scatter_t got;
        scatter_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tuser[0], m_axis_tuser[1]};
            if (scatter_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                want = scatter_q.pop_front();
                checked_count++;
                refl_count += want.refl;
                tir_count += want.tir;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: dir %h %h %h refl %b tir %b, expected %h %h %h refl %b tir %b",
                                 got.dx, got.dy, got.dz, got.refl, got.tir,
                                 want.dx, want.dy, want.dz, want.refl, want.tir);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #(40_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        ray_row_t rows[$];
        ray_row_t row;
        logic [13:0] settings[5];
        int hold_len;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        mismatch_count = 0;
        checked_count = 0;
        refl_count = 0;
        tir_count = 0;
        send_idle_pct = 16;
        recv_idle_pct = 80;
        index_reg = IDX_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset index 1.5
        row.typed = 1'b1;
        // Zero direction: takes the entering case with dt zero, glancing, reflects
        row.ray = pack_ray(0, 0, 0, 0, 0, 4096, 0);
        row.answer = '{16'h0, 16'h0, 16'h0, 1'b1, 1'b0};
        rows.push_back(row);
        // Head-on entering ray, random at top: straight refraction
        row.ray = pack_ray(0, 0, -4096, 0, 0, 4096, 65535);
        row.answer = '{16'h0, 16'h0, 16'hf000, 1'b0, 1'b0};
        rows.push_back(row);
        // Same ray, random zero: reflects back up
        row.ray = pack_ray(0, 0, -4096, 0, 0, 4096, 0);
        row.answer = '{16'h0, 16'h0, 16'h1000, 1'b1, 1'b0};
        rows.push_back(row);
        row.typed = 1'b0;
        // Extremes of direction and normal, saturation, grazing and exiting rays
        rows.push_back('{pack_ray(32767, 32767, 32767, 4096, 0, 0, 30000), 0, '0});
        rows.push_back('{pack_ray(-32768, -32768, -32768, 0, 4096, 0, 100), 0, '0});
        rows.push_back('{pack_ray(-32768, 32767, -32768, 32767, -32768, 32767, 5), 0, '0});
        rows.push_back('{pack_ray(32767, -32768, 32767, -32768, 32767, -32768, 65535), 0, '0});
        rows.push_back('{pack_ray(4000, 0, 900, 0, 0, 4096, 65535), 0, '0});
        rows.push_back('{pack_ray(3000, 0, 2800, 0, 0, 4096, 65535), 0, '0});
        rows.push_back('{pack_ray(0, 0, 4096, 0, 0, 4096, 65535), 0, '0});
        rows.push_back('{pack_ray(2896, 0, -2896, 0, 0, 4096, 20000), 0, '0});
        rows.push_back('{pack_ray(100, -200, 50, 2000, 2000, 1000, 1), 0, '0});
        rows.push_back('{pack_ray(1, -1, 1, -1, 1, -1, 32768), 0, '0});
        foreach (rows[i])
        begin
            send_ray(rows[i].ray);
            if (rows[i].typed && scatter_q[$] !== rows[i].answer)
            begin
                mismatch_count++;
                $display("ERROR: directed row %0d predicted %h, expected %h",
                         i, scatter_q[$], rows[i].answer);
            end
        end
        drain_pipeline();

        // Index settings: 1.0, zero (also taken as 1.0), high extreme, glass, reset
        settings = '{14'd4096, 14'd0, 14'd16383, 14'd6200, IDX_RESET};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_index(settings[ph]);
            if (ph == 2)
                send_idle_pct = 80;
            if (ph == 2)
                recv_idle_pct = 16;
            if (ph == 4)
                send_idle_pct = 0;
            if (ph == 4)
                recv_idle_pct = 0;
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                // Long hold-off so the pipeline fills and backs up the input
                if (ph == 4 && i == 20)
                begin
                    fork
                        begin
                            hold_len = 0;
                            hold_off = 1'b1;
                            while (hold_len < 150)
                            begin
                                @(posedge clk);
                                hold_len++;
                            end
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_ray(random_ray());
            end
            drain_pipeline();
        end

        $display("Checked %0d rays over 6 index settings: %0d reflected, %0d total internal.",
                 checked_count, refl_count, tir_count);
        if (mismatch_count == 0 && scatter_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
